### sv/skt_pkg.sv
package skt_pkg;

  localparam int unsigned Capacity   = 128;
  localparam int unsigned KeyBits    = 16;
  localparam int unsigned HandleBits = 10;
  localparam int unsigned AddrBits   = $clog2(Capacity);
  localparam int unsigned CountBits  = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [9:0]  handle;
    logic [6:0]  position;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key_out;
    logic [9:0]  handle_out;
    logic [7:0]  count_out;
  } rsp_t;

  // One table entry as held in memory
  typedef struct packed {
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
  } entry_t;

  // Memory port request from the sequencer
  typedef struct packed {
    logic                re;
    logic [AddrBits-1:0] raddr;
    logic                we;
    logic [AddrBits-1:0] waddr;
    entry_t              wdata;
  } mem_req_t;

endpackage

### sv/skt_ram.sv
module skt_ram import skt_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t mreq_i,
  output entry_t   rdata_o
);

  entry_t mem_q [Capacity];

  // Write one entry, read one entry; the read data is registered
  always_ff @(posedge clk_i) begin
    if (mreq_i.we) begin
      mem_q[mreq_i.waddr] <= mreq_i.wdata;
    end
    if (mreq_i.re) begin
      rdata_o <= mem_q[mreq_i.raddr];
    end
  end

endmodule

### sv/skt_ctrl.sv
module skt_ctrl import skt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  req_t     req_i,
  output logic     busy_o,
  output logic     done_o,
  output rsp_t     rsp_o,
  output mem_req_t mreq_o,
  input  entry_t   rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_PROBE, S_PWAIT, S_SHIFT, S_SWRITE
  } state_e;

  state_e               state_q;
  req_t                 req_q;
  logic [CountBits-1:0] count_q, lo_q, hi_q, idx_q;
  logic                 done_q;
  rsp_t                 rsp_q;
  mem_req_t             mreq;

  logic [KeyBits-1:0]    k;
  logic [HandleBits-1:0] h;
  logic [CountBits-1:0]  mid, pos_ext;
  logic                  full, hit;

  assign k       = req_q.key[KeyBits-1:0];
  assign h       = req_q.handle[HandleBits-1:0];
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign pos_ext = CountBits'(req_q.position);
  assign full    = (count_q >= CountBits'(Capacity));
  assign hit     = (lo_q < count_q) && (rdata_i.key == k);

  // Drive the memory port from the current step
  always_comb begin
    mreq = '0;
    unique case (state_q)
      S_SRCH: begin
        mreq.re    = (lo_q < hi_q);
        mreq.raddr = mid[AddrBits-1:0];
      end
      S_PROBE: begin
        mreq.re    = 1'b1;
        mreq.raddr = (req_q.req_type == REQ_READ) ? pos_ext[AddrBits-1:0]
                                                  : lo_q[AddrBits-1:0];
      end
      S_SHIFT: begin
        mreq.re = 1'b1;
        if (req_q.req_type == REQ_INSERT) begin
          mreq.raddr = AddrBits'(idx_q - 1'b1);
        end else begin
          mreq.raddr = AddrBits'(idx_q + 1'b1);
        end
      end
      S_SWRITE: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_q[AddrBits-1:0];
        mreq.wdata = rdata_i;
      end
      default: ;
    endcase
    // Final insert write of the new entry
    if (state_q == S_SHIFT && req_q.req_type == REQ_INSERT && idx_q == lo_q) begin
      mreq.re          = 1'b0;
      mreq.we          = 1'b1;
      mreq.waddr       = lo_q[AddrBits-1:0];
      mreq.wdata.key    = k;
      mreq.wdata.handle = h;
    end
  end

  assign mreq_o = mreq;

  // Sequence search, probe and shift steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      req_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      idx_q   <= '0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q   <= req_i;
            lo_q    <= '0;
            hi_q    <= count_q;
            state_q <= (req_i.req_type == REQ_READ) ? S_PROBE : S_SRCH;
          end
        end
        S_SRCH: begin
          state_q <= (lo_q < hi_q) ? S_SWAIT : S_PROBE;
        end
        S_SWAIT: begin
          if (rdata_i.key < k) begin
            lo_q <= mid + 1'b1;
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH;
        end
        S_PROBE: state_q <= S_PWAIT;
        S_PWAIT: begin
          rsp_q     <= '0;
          state_q   <= S_IDLE;
          done_q    <= 1'b1;
          unique case (req_q.req_type)
            REQ_INSERT: begin
              if (full) begin
                rsp_q.status    <= ST_FULL;
                rsp_q.count_out <= 8'(count_q);
              end else if (hit) begin
                rsp_q.status    <= ST_DUP;
                rsp_q.count_out <= 8'(count_q);
              end else begin
                idx_q   <= count_q;
                state_q <= S_SHIFT;
                done_q  <= 1'b0;
              end
            end
            REQ_REMOVE: begin
              if (!hit) begin
                rsp_q.status    <= ST_NOTFOUND;
                rsp_q.count_out <= 8'(count_q);
              end else begin
                idx_q   <= lo_q;
                state_q <= S_SHIFT;
                done_q  <= 1'b0;
              end
            end
            REQ_FIND: begin
              rsp_q.count_out <= 8'(count_q);
              if (!hit) begin
                rsp_q.status <= ST_NOTFOUND;
              end else begin
                rsp_q.key_out    <= 16'(rdata_i.key);
                rsp_q.handle_out <= 10'(rdata_i.handle);
              end
            end
            REQ_READ: begin
              rsp_q.count_out <= 8'(count_q);
              if (pos_ext >= count_q) begin
                rsp_q.status <= ST_RANGE;
              end else begin
                rsp_q.key_out    <= 16'(rdata_i.key);
                rsp_q.handle_out <= 10'(rdata_i.handle);
              end
            end
            default: ;
          endcase
        end
        S_SHIFT: begin
          if (req_q.req_type == REQ_INSERT) begin
            if (idx_q == lo_q) begin
              count_q         <= count_q + 1'b1;
              rsp_q.count_out <= 8'(count_q + 1'b1);
              done_q          <= 1'b1;
              state_q         <= S_IDLE;
            end else begin
              state_q <= S_SWRITE;
            end
          end else begin
            if (idx_q + 1'b1 >= count_q) begin
              count_q         <= count_q - 1'b1;
              rsp_q.count_out <= 8'(count_q - 1'b1);
              done_q          <= 1'b1;
              state_q         <= S_IDLE;
            end else begin
              state_q <= S_SWRITE;
            end
          end
        end
        S_SWRITE: begin
          idx_q   <= (req_q.req_type == REQ_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
          state_q <= S_SHIFT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(Capacity)) else $error("count above capacity");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result while busy");
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mreq.we && mreq.re)) else $error("read and write together");

endmodule

### sv/sorted_key_table.sv
// Find and refused requests run a binary search and then a probe; read by position runs only the probe;
// insert and remove then move each entry with a read and a write, since the RAM has one request port.
// Throughput: one request at a time; start is taken only while busy is low.
// Result shows for one cycle on done_o; the receiver cannot stall it.
// Reset clears the entry count and the control registers; the entry RAM is not cleared.
module sorted_key_table import skt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  mem_req_t mreq;
  entry_t   rdata;

  skt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .mreq_o  (mreq),
    .rdata_i (rdata)
  );

  skt_ram u_ram (
    .clk_i   (clk_i),
    .mreq_i  (mreq),
    .rdata_o (rdata)
  );

endmodule
